FILE: rtl/ora_pkg.sv
// shared types and constants for the resource ownership arbiter
package ora_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int FIELD_W         = 32;

  typedef enum logic [2:0] {
    OUT_NEW     = 3'd0,
    OUT_ALREADY = 3'd1,
    OUT_TAKEN   = 3'd2,
    OUT_DENIED  = 3'd3,
    OUT_FULL    = 3'd4
  } outcome_t;

  // one ownership record, also the request payload
  typedef struct packed {
    logic [FIELD_W-1:0] owner;
    logic [FIELD_W-1:0] res_id;
    logic [FIELD_W-1:0] res_type;
  } entry_t;

  typedef struct packed {
    logic [FIELD_W-1:0] holder;
    outcome_t           outcome;
    logic               granted;
  } result_t;

  localparam int ENTRY_W  = $bits(entry_t);
  localparam int RESULT_W = $bits(result_t);

endpackage

FILE: rtl/ora_ram.sv
// generic single write port ram with registered read
module ora_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ora_engine.sv
// table scan, decision and write-back sequencer around the record ram
module ora_engine import ora_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
  localparam int CW = $clog2(TABLE_SLOTS + 1)
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  entry_t  req,
  input  logic    takeover_mode,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  entry_t           cur;
  logic [CW-1:0]    issue_cnt;
  logic             rd_live;
  logic [IW-1:0]    rd_idx;
  logic             vld_q;
  logic             have_free;
  logic [IW-1:0]    first_free;
  logic [TABLE_SLOTS-1:0] vld;

  entry_t           rdata;
  logic [ENTRY_W-1:0] rdata_raw;
  logic             we;
  logic [IW-1:0]    waddr;
  entry_t           wdata;
  logic [IW-1:0]    raddr;
  logic             issuing;
  logic [FIELD_W-1:0] rd_owner;
  logic             slot_match;
  logic             scan_end;
  logic             finish;
  result_t          res_next;

  ora_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata     = entry_t'(rdata_raw);
  assign raddr     = issue_cnt[IW-1:0];
  assign issuing   = (state == ST_SCAN) && (issue_cnt != CW'(TABLE_SLOTS));
  // slot never written since reset reads as free
  assign rd_owner  = vld_q ? rdata.owner : '0;
  assign slot_match = rd_live && (rd_owner != '0) &&
                      (rdata.res_type == cur.res_type) && (rdata.res_id == cur.res_id);
  assign scan_end  = !rd_live && (issue_cnt == CW'(TABLE_SLOTS));
  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign wdata     = cur;

  always_comb begin
    we       = 1'b0;
    waddr    = rd_idx;
    finish   = 1'b0;
    res_next = res;
    if (state == ST_SCAN) begin
      if (slot_match) begin
        finish = 1'b1;
        if (rdata.owner == cur.owner) begin
          res_next = '{holder: cur.owner, outcome: OUT_ALREADY, granted: 1'b1};
        end else if (takeover_mode) begin
          we       = 1'b1;
          res_next = '{holder: cur.owner, outcome: OUT_TAKEN, granted: 1'b1};
        end else begin
          res_next = '{holder: rdata.owner, outcome: OUT_DENIED, granted: 1'b0};
        end
      end else if (scan_end) begin
        finish = 1'b1;
        if (have_free) begin
          we       = 1'b1;
          waddr    = first_free;
          res_next = '{holder: cur.owner, outcome: OUT_NEW, granted: 1'b1};
        end else begin
          res_next = '{holder: '0, outcome: OUT_FULL, granted: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      rd_live   <= 1'b0;
      have_free <= 1'b0;
      issue_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state     <= ST_SCAN;
            issue_cnt <= '0;
            rd_live   <= 1'b0;
            have_free <= 1'b0;
          end
        end
        ST_SCAN: begin
          rd_live <= issuing;
          if (issuing) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (rd_live && (rd_owner == '0) && !have_free) begin
            have_free <= 1'b1;
          end
          if (we) begin
            vld[waddr] <= 1'b1;
          end
          if (finish) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    rd_idx <= raddr;
    vld_q  <= vld[raddr];
    if (rd_live && (rd_owner == '0) && !have_free) begin
      first_free <= rd_idx;
    end
    if (finish) begin
      res <= res_next;
    end
  end

endmodule

FILE: rtl/resource_ownership_arbiter.sv
// resource ownership arbiter: one request in, one grant/deny result out
// the record ram is scanned one slot per cycle from request transfer until a match
//   or the end of the table; a match ends the scan early
// a new request is taken only after the engine has handed on the result of the last one
// reset: rst clears control, takeover_mode and all slot valid bits; the table
//   reads as all free right after reset with no clearing pass
module resource_ownership_arbiter import ora_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,   // takeover_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,    // res_type[31:0], res_id[63:32], requester[95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata     // granted[0], outcome[3:1], holder[35:4], zero[39:36]
);

  logic    takeover_mode;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;
  entry_t  req;

  assign cfg_ready = 1'b1;
  assign req       = entry_t'(s_tdata);

  ora_engine #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (s_tvalid),
    .req_ready     (s_tready),
    .req           (req),
    .takeover_mode (takeover_mode),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output register frees the engine while a result waits
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      takeover_mode <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        takeover_mode <= cfg_data;
      end
      if (res_ready) begin
        m_tvalid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'd0, out_res};

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while scan busy");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:1] == OUT_NEW || m_tdata[3:1] == OUT_ALREADY ||
                  m_tdata[3:1] == OUT_TAKEN || m_tdata[3:1] == OUT_DENIED ||
                  m_tdata[3:1] == OUT_FULL))
    else $error("bad outcome code");

  a_grant_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == OUT_NEW || m_tdata[3:1] == OUT_ALREADY ||
                                 m_tdata[3:1] == OUT_TAKEN)))
    else $error("granted flag disagrees with outcome");

  a_full_holder: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:1] == OUT_FULL) |-> (m_tdata[35:4] == '0))
    else $error("holder nonzero on full table");

endmodule
